@@ sv/prrt_pkg.sv @@
// shared types, codes and defaults for the priority rectangle region table
// no dependencies
package prrt_pkg;

   localparam int MAX_REGIONS_DEF  = 64;
   localparam int COORD_BITS_DEF   = 16;
   localparam int TEXTURE_BITS_DEF = 16;

   localparam int CFG_WIDTH = 15;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CFG_WIDTH-1:0] CFG_RESET_VALUE = 15'd64;

   localparam logic [1:0] CMD_ADD         = 2'd0;
   localparam logic [1:0] CMD_SET_FLOOR   = 2'd1;
   localparam logic [1:0] CMD_SET_CEILING = 2'd2;
   localparam logic [1:0] CMD_LOOKUP      = 2'd3;

   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_BOUNDS   = 3'd1;
   localparam logic [2:0] STAT_FULL     = 3'd2;
   localparam logic [2:0] STAT_INDEX    = 3'd3;
   localparam logic [2:0] STAT_NO_MATCH = 3'd4;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GRID_COLUMNS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GRID_ROWS    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TILE_SIZE    = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [15:0] x_low;
      logic signed [15:0] y_low;
      logic signed [15:0] x_high;
      logic signed [15:0] y_high;
      logic [9:0]         region_index;
      logic signed [31:0] height;
      logic [15:0]        texture;
      logic               ceiling_present;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [9:0]         found_index;
      logic signed [31:0] floor_level;
      logic signed [31:0] ceiling_level;
      logic [15:0]        floor_tex;
      logic [15:0]        ceiling_tex;
      logic               has_roof;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_PRIME,
      S_SCAN,
      S_FETCH
   } state_type;

   typedef struct packed {
      logic latch;
      logic do_add;
      logic do_set;
      logic scan_init;
      logic scan_step;
      logic latch_hit;
      logic emit_hit;
      logic emit_miss;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic       count_zero;
      logic       hit;
      logic       last;
   } ctrl_stat_type;

endpackage

@@ sv/priority_rect_region_table.sv @@
// top level of the priority rectangle region table: controller plus datapath
// add and set items, and lookups on an empty table, answer from the execute state; other
// lookups prime the scan, then check one entry per cycle via the registered bounds read,
// highest index first; a miss answers after the last entry, a hit fetches the entry data
// throughput: one item at a time, busy drops as the result shows; results cannot be stalled
// synchronous reset empties the table and sets every config register to 64; memories kept
module priority_rect_region_table #(
   parameter int MAX_REGIONS  = prrt_pkg::MAX_REGIONS_DEF,
   parameter int COORD_BITS   = prrt_pkg::COORD_BITS_DEF,
   parameter int TEXTURE_BITS = prrt_pkg::TEXTURE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  prrt_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   output prrt_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [prrt_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [prrt_pkg::CFG_WIDTH-1:0]       csr_wdata
);
   import prrt_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   prrt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   prrt_dp #(
      .MAX_REGIONS  (MAX_REGIONS),
      .COORD_BITS   (COORD_BITS),
      .TEXTURE_BITS (TEXTURE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ sv/prrt_ctrl.sv @@
// controller state machine for the region table
// depends on prrt_pkg
module prrt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  prrt_pkg::ctrl_stat_type stat,
   output prrt_pkg::ctrl_cmd_type  cmd
);
   import prrt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.command == CMD_LOOKUP && !stat.count_zero) begin
               state_in = S_PRIME;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PRIME: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (stat.hit) begin
               state_in = S_FETCH;
            end else if (stat.last) begin
               state_in = S_IDLE;
            end
         end
         S_FETCH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            busy      = 1'b0;
            cmd.latch = start;
         end
         S_EXEC: begin
            unique case (stat.command)
               CMD_ADD: begin
                  cmd.do_add = 1'b1;
               end
               CMD_SET_FLOOR, CMD_SET_CEILING: begin
                  cmd.do_set = 1'b1;
               end
               default: begin
                  if (stat.count_zero) begin
                     cmd.emit_miss = 1'b1;
                  end else begin
                     cmd.scan_init = 1'b1;
                  end
               end
            endcase
         end
         S_PRIME: begin
            cmd.scan_step = 1'b1;
         end
         S_SCAN: begin
            if (stat.hit) begin
               cmd.latch_hit = 1'b1;
            end else if (stat.last) begin
               cmd.emit_miss = 1'b1;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_FETCH: begin
            cmd.emit_hit = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ sv/prrt_dp.sv @@
// datapath: configuration registers, entry memories, scan pipeline, result register
// depends on prrt_pkg
module prrt_dp #(
   parameter int MAX_REGIONS  = prrt_pkg::MAX_REGIONS_DEF,
   parameter int COORD_BITS   = prrt_pkg::COORD_BITS_DEF,
   parameter int TEXTURE_BITS = prrt_pkg::TEXTURE_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  prrt_pkg::req_type                        req_data,
   input  logic                                     csr_we,
   input  logic [prrt_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [prrt_pkg::CFG_WIDTH-1:0]           csr_wdata,
   input  prrt_pkg::ctrl_cmd_type                   cmd,
   output prrt_pkg::ctrl_stat_type                  stat,
   output logic                                     rsp_valid,
   output prrt_pkg::rsp_type                        rsp_data
);
   import prrt_pkg::*;

   localparam int IW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNTW = $clog2(MAX_REGIONS + 1);
   localparam int CW   = (COORD_BITS < 16) ? COORD_BITS : 16;
   localparam int TB   = (TEXTURE_BITS < 16) ? TEXTURE_BITS : 16;
   localparam int BW   = 4 * CW;
   localparam int FW   = 32 + TB;
   localparam int CEW  = 32 + TB + 1;
   localparam int XW   = 17;

   // configuration
   logic [CFG_WIDTH-1:0] grid_columns_ff;
   logic [CFG_WIDTH-1:0] grid_rows_ff;
   logic [CFG_WIDTH-1:0] tile_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff <= CFG_RESET_VALUE;
         grid_rows_ff    <= CFG_RESET_VALUE;
         tile_size_ff    <= CFG_RESET_VALUE;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GRID_COLUMNS: grid_columns_ff <= csr_wdata;
            REG_GRID_ROWS:    grid_rows_ff    <= csr_wdata;
            REG_TILE_SIZE:    tile_size_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // latched item
   req_type req_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_data;
      end
   end

   logic signed [CW-1:0] xl;
   logic signed [CW-1:0] yl;
   logic signed [CW-1:0] xh;
   logic signed [CW-1:0] yh;
   logic signed [XW-1:0] xh_ext;
   logic signed [XW-1:0] yh_ext;
   logic signed [XW-1:0] cols_ext;
   logic signed [XW-1:0] rows_ext;

   assign xl       = req_ff.x_low[CW-1:0];
   assign yl       = req_ff.y_low[CW-1:0];
   assign xh       = req_ff.x_high[CW-1:0];
   assign yh       = req_ff.y_high[CW-1:0];
   assign xh_ext   = {{(XW-CW){xh[CW-1]}}, xh};
   assign yh_ext   = {{(XW-CW){yh[CW-1]}}, yh};
   assign cols_ext = {2'b00, grid_columns_ff};
   assign rows_ext = {2'b00, grid_rows_ff};

   logic count_ok_full;
   logic bounds_bad;
   logic index_bad;
   logic [CNTW-1:0] count_ff;
   logic [CNTW-1:0] count_in;
   logic [CNTW-1:0] count_dec;

   assign bounds_bad = xl[CW-1] || yl[CW-1] || (xh_ext >= cols_ext) ||
                       (yh_ext >= rows_ext) || (xl > xh) || (yl > yh);
   assign count_ok_full = (count_ff >= CNTW'(MAX_REGIONS));
   assign index_bad = ({1'b0, req_ff.region_index} >= 11'(count_ff));
   assign count_dec = count_ff - CNTW'(1);

   logic add_ok;
   logic set_ok;

   assign add_ok = cmd.do_add && !bounds_bad && !count_ok_full;
   assign set_ok = cmd.do_set && !index_bad;

   always_comb begin
      count_in = count_ff;
      if (add_ok) begin
         count_in = count_ff + CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // entry memories
   logic [BW-1:0]  bounds_mem [MAX_REGIONS];
   logic [FW-1:0]  floor_mem  [MAX_REGIONS];
   logic [CEW-1:0] ceil_mem   [MAX_REGIONS];

   logic           floor_we;
   logic           ceil_we;
   logic [IW-1:0]  wr_addr;
   logic [FW-1:0]  floor_wd;
   logic [CEW-1:0] ceil_wd;
   logic [31:0]    tile_height;

   assign tile_height = {1'b0, tile_size_ff, 16'h0000};

   always_comb begin
      floor_we = 1'b0;
      ceil_we  = 1'b0;
      wr_addr  = req_ff.region_index[IW-1:0];
      floor_wd = {req_ff.height, req_ff.texture[TB-1:0]};
      ceil_wd  = {req_ff.height, req_ff.texture[TB-1:0], req_ff.ceiling_present};
      if (add_ok) begin
         floor_we = 1'b1;
         ceil_we  = 1'b1;
         wr_addr  = count_ff[IW-1:0];
         floor_wd = '0;
         ceil_wd  = {tile_height, {TB{1'b0}}, 1'b1};
      end else if (set_ok) begin
         floor_we = (req_ff.command == CMD_SET_FLOOR);
         ceil_we  = (req_ff.command == CMD_SET_CEILING);
      end
   end

   always_ff @(posedge clock) begin
      if (add_ok) begin
         bounds_mem[wr_addr] <= {xl, yl, xh, yh};
      end
      if (floor_we) begin
         floor_mem[wr_addr] <= floor_wd;
      end
      if (ceil_we) begin
         ceil_mem[wr_addr] <= ceil_wd;
      end
   end

   // scan pipeline, highest index first
   logic [IW-1:0]  scan_addr_ff;
   logic [IW-1:0]  rd_addr_ff;
   logic           rd_last_ff;
   logic [BW-1:0]  bnd_rd_ff;
   logic [FW-1:0]  floor_rd_ff;
   logic [CEW-1:0] ceil_rd_ff;
   logic [IW-1:0]  match_idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         scan_addr_ff <= count_dec[IW-1:0];
      end else if (cmd.scan_step && scan_addr_ff != '0) begin
         scan_addr_ff <= scan_addr_ff - IW'(1);
      end
      if (cmd.scan_step) begin
         rd_last_ff <= (scan_addr_ff == '0);
      end
      if (cmd.latch_hit) begin
         match_idx_ff <= rd_addr_ff;
      end
      rd_addr_ff  <= scan_addr_ff;
      bnd_rd_ff   <= bounds_mem[scan_addr_ff];
      floor_rd_ff <= floor_mem[rd_addr_ff];
      ceil_rd_ff  <= ceil_mem[rd_addr_ff];
   end

   logic signed [CW-1:0] r_xl;
   logic signed [CW-1:0] r_yl;
   logic signed [CW-1:0] r_xh;
   logic signed [CW-1:0] r_yh;
   logic                 hit;

   assign {r_xl, r_yl, r_xh, r_yh} = bnd_rd_ff;
   assign hit = (xl >= r_xl) && (xl <= r_xh) && (yl >= r_yl) && (yl <= r_yh);

   assign stat.command    = req_ff.command;
   assign stat.count_zero = (count_ff == '0);
   assign stat.hit        = hit;
   assign stat.last       = rd_last_ff;

   // result register
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   always_comb begin
      rsp_valid_in = cmd.do_add || cmd.do_set || cmd.emit_hit || cmd.emit_miss;
      rsp_in       = '0;
      if (cmd.do_add) begin
         if (bounds_bad) begin
            rsp_in.status = STAT_BOUNDS;
         end else if (count_ok_full) begin
            rsp_in.status = STAT_FULL;
         end else begin
            rsp_in.status      = STAT_OK;
            rsp_in.found_index = 10'(count_ff);
         end
      end else if (cmd.do_set) begin
         rsp_in.status = index_bad ? STAT_INDEX : STAT_OK;
      end else if (cmd.emit_miss) begin
         rsp_in.status = STAT_NO_MATCH;
      end else if (cmd.emit_hit) begin
         rsp_in.status        = STAT_OK;
         rsp_in.found_index   = 10'(match_idx_ff);
         rsp_in.floor_level   = floor_rd_ff[FW-1:TB];
         rsp_in.floor_tex     = 16'(floor_rd_ff[TB-1:0]);
         rsp_in.ceiling_level = ceil_rd_ff[CEW-1:TB+1];
         rsp_in.ceiling_tex   = 16'(ceil_rd_ff[TB:1]);
         rsp_in.has_roof      = ceil_rd_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ tb/priority_rect_region_table_tb.sv @@
// self-checking testbench for priority_rect_region_table: directed and random item traffic
// predicts every response from an internal copy of the region table and grid settings
// depends on prrt_pkg and priority_rect_region_table
module priority_rect_region_table_tb;
   import prrt_pkg::*;

   localparam int MAX_REGIONS = MAX_REGIONS_DEF;
   localparam int STALL_LIMIT = 2000;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   req_type                    req_data = '0;
   logic                       rsp_valid;
   rsp_type                    rsp_data;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CFG_WIDTH-1:0]       csr_wdata = '0;

   // predicted table contents and grid settings
   logic [CFG_WIDTH-1:0] grid_cols_q = CFG_RESET_VALUE;
   logic [CFG_WIDTH-1:0] grid_rows_q = CFG_RESET_VALUE;
   logic [CFG_WIDTH-1:0] grid_tile_q = CFG_RESET_VALUE;
   int                   table_count = 0;
   int                   box_xl [MAX_REGIONS];
   int                   box_yl [MAX_REGIONS];
   int                   box_xh [MAX_REGIONS];
   int                   box_yh [MAX_REGIONS];
   logic signed [31:0]   floor_h [MAX_REGIONS];
   logic [15:0]          floor_t [MAX_REGIONS];
   logic signed [31:0]   ceil_h [MAX_REGIONS];
   logic [15:0]          ceil_t [MAX_REGIONS];
   logic                 ceil_on [MAX_REGIONS];

   rsp_type expected_responses[$];
   rsp_type want;
   int      error_count = 0;
   int      stall_cycles = 0;
   bit      steady = 1'b0;

   priority_rect_region_table DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_type region_table_response(input req_type item);
      rsp_type res;
      int      xl, yl, xh, yh, n, idx;
      res = '0;
      xl = $signed(item.x_low);
      yl = $signed(item.y_low);
      xh = $signed(item.x_high);
      yh = $signed(item.y_high);
      idx = item.region_index;
      case (item.command)
         CMD_ADD: begin
            if (xl < 0 || yl < 0 || xh >= int'(grid_cols_q) || yh >= int'(grid_rows_q) ||
                xl > xh || yl > yh) begin
               res.status = STAT_BOUNDS;
            end else if (table_count >= MAX_REGIONS) begin
               res.status = STAT_FULL;
            end else begin
               n = table_count;
               box_xl[n] = xl;
               box_yl[n] = yl;
               box_xh[n] = xh;
               box_yh[n] = yh;
               floor_h[n] = '0;
               floor_t[n] = '0;
               ceil_h[n] = {1'b0, grid_tile_q, 16'h0000};
               ceil_t[n] = '0;
               ceil_on[n] = 1'b1;
               table_count = n + 1;
               res.status = STAT_OK;
               res.found_index = 10'(n);
            end
         end
         CMD_SET_FLOOR, CMD_SET_CEILING: begin
            if (idx >= table_count) begin
               res.status = STAT_INDEX;
            end else if (item.command == CMD_SET_FLOOR) begin
               floor_h[idx] = item.height;
               floor_t[idx] = item.texture;
               res.status = STAT_OK;
            end else begin
               ceil_h[idx] = item.height;
               ceil_t[idx] = item.texture;
               ceil_on[idx] = item.ceiling_present;
               res.status = STAT_OK;
            end
         end
         default: begin
            res.status = STAT_NO_MATCH;
            for (n = table_count - 1; n >= 0; n--) begin
               if (xl >= box_xl[n] && xl <= box_xh[n] && yl >= box_yl[n] && yl <= box_yh[n]) begin
                  res.status = STAT_OK;
                  res.found_index = 10'(n);
                  res.floor_level = floor_h[n];
                  res.ceiling_level = ceil_h[n];
                  res.floor_tex = floor_t[n];
                  res.ceiling_tex = ceil_t[n];
                  res.has_roof = ceil_on[n];
                  break;
               end
            end
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_responses.size() == 0) begin
            $error("unexpected response, status %0d", rsp_data.status);
            error_count++;
         end else begin
            want = expected_responses.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.found_index !== want.found_index) begin
               $error("found_index: expected %0d, got %0d", want.found_index,
                      rsp_data.found_index);
               error_count++;
            end
            if (rsp_data.floor_level !== want.floor_level) begin
               $error("floor_level: expected %h, got %h", want.floor_level,
                      rsp_data.floor_level);
               error_count++;
            end
            if (rsp_data.ceiling_level !== want.ceiling_level) begin
               $error("ceiling_level: expected %h, got %h", want.ceiling_level,
                      rsp_data.ceiling_level);
               error_count++;
            end
            if (rsp_data.floor_tex !== want.floor_tex) begin
               $error("floor_tex: expected %h, got %h", want.floor_tex, rsp_data.floor_tex);
               error_count++;
            end
            if (rsp_data.ceiling_tex !== want.ceiling_tex) begin
               $error("ceiling_tex: expected %h, got %h", want.ceiling_tex,
                      rsp_data.ceiling_tex);
               error_count++;
            end
            if (rsp_data.has_roof !== want.has_roof) begin
               $error("has_roof: expected %b, got %b", want.has_roof, rsp_data.has_roof);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || csr_we || (start && !busy)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("priority_rect_region_table: mismatch");
            $finish;
         end
      end
   end

   function automatic req_type noise_item();
      req_type item;
      item.command = 2'($urandom_range(0, 3));
      item.x_low = 16'($urandom);
      item.y_low = 16'($urandom);
      item.x_high = 16'($urandom);
      item.y_high = 16'($urandom);
      item.region_index = 10'($urandom);
      item.height = $urandom;
      item.texture = 16'($urandom);
      item.ceiling_present = 1'($urandom);
      return item;
   endfunction

   function automatic req_type make_add(input int xl, input int yl, input int xh, input int yh);
      req_type item;
      item = noise_item();
      item.command = CMD_ADD;
      item.x_low = 16'(xl);
      item.y_low = 16'(yl);
      item.x_high = 16'(xh);
      item.y_high = 16'(yh);
      return item;
   endfunction

   function automatic req_type make_lookup(input int x, input int y);
      req_type item;
      item = noise_item();
      item.command = CMD_LOOKUP;
      item.x_low = 16'(x);
      item.y_low = 16'(y);
      return item;
   endfunction

   function automatic req_type make_set(input logic [1:0] cmd, input int idx,
                                        input logic [31:0] h, input logic [15:0] tex,
                                        input logic pres);
      req_type item;
      item = noise_item();
      item.command = cmd;
      item.region_index = 10'(idx);
      item.height = h;
      item.texture = tex;
      item.ceiling_present = pres;
      return item;
   endfunction

   function automatic logic [CFG_WIDTH-1:0] pick_dimension();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 15'd1;
         2: return 15'h7FFF;
         3, 4: return 15'($urandom_range(1, 32767));
         default: return 15'($urandom_range(1, 40));
      endcase
   endfunction

   task automatic send_item(input req_type item);
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      expected_responses.push_back(region_table_response(item));
      if (!steady && $urandom_range(0, 99) < 17) begin
         start <= 1'b0;
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 72) : $urandom_range(1, 3))
            @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_responses.size() != 0 || busy) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // only call once the table is idle
   task automatic program_grid(input logic [CFG_WIDTH-1:0] cols,
                               input logic [CFG_WIDTH-1:0] rows,
                               input logic [CFG_WIDTH-1:0] tile, input bit spare);
      logic [CFG_WIDTH-1:0]       vals [4];
      logic [CSR_INDEX_WIDTH-1:0] regs [4];
      int                         n;
      vals = '{cols, rows, tile, 15'($urandom)};
      regs = '{REG_GRID_COLUMNS, REG_GRID_ROWS, REG_TILE_SIZE, REG_SPARE};
      csr_we <= 1'b1;
      for (n = 0; n < (spare ? 4 : 3); n++) begin
         csr_index <= regs[n];
         csr_wdata <= vals[n];
         @(posedge clock);
         case (regs[n])
            REG_GRID_COLUMNS: grid_cols_q = vals[n];
            REG_GRID_ROWS:    grid_rows_q = vals[n];
            REG_TILE_SIZE:    grid_tile_q = vals[n];
            default: ;
         endcase
      end
      csr_we <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_item(make_lookup(0, 0));
      send_item(make_add(0, 0, 63, 63));
      send_item(make_add(10, 10, 20, 20));
      send_item(make_lookup(15, 15));
      send_item(make_lookup(0, 0));
      send_item(make_lookup(63, 63));
      send_item(make_lookup(64, 0));
   endtask

   task automatic test_bounds_checks();
      send_item(make_add(-1, 0, 5, 5));
      send_item(make_add(0, -1, 5, 5));
      send_item(make_add(0, 0, 64, 5));
      send_item(make_add(0, 0, 5, 64));
      send_item(make_add(6, 0, 5, 5));
      send_item(make_add(0, 6, 5, 5));
      send_item(make_add(-32768, -32768, 32767, 32767));
      send_item(make_add(63, 63, 63, 63));
   endtask

   task automatic test_set_commands();
      send_item(make_set(CMD_SET_FLOOR, 1, 32'h8000_0000, 16'hFFFF, 1'b1));
      send_item(make_set(CMD_SET_CEILING, 1, 32'h7FFF_FFFF, 16'h0000, 1'b0));
      send_item(make_lookup(15, 15));
      send_item(make_set(CMD_SET_FLOOR, 3, 32'h0001_0000, 16'h1234, 1'b1));
      send_item(make_set(CMD_SET_CEILING, 1023, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
   endtask

   task automatic test_grid_extremes();
      drain();
      program_grid(15'd0, 15'd64, 15'd64, 1'b1);
      send_item(make_add(0, 0, 0, 0));
      drain();
      program_grid(15'h7FFF, 15'h7FFF, 15'h7FFF, 1'b0);
      send_item(make_add(0, 0, 32766, 32766));
      send_item(make_lookup(32766, 32766));
      drain();
      program_grid(15'd1, 15'd1, 15'd0, 1'b1);
      send_item(make_add(0, 0, 0, 0));
      send_item(make_lookup(0, 0));
      drain();
   endtask

   task automatic test_random_traffic();
      req_type item;
      int      phase, k, roll, cols, rows, pick;
      int      xl, yl;
      for (phase = 0; phase < 11; phase++) begin
         drain();
         program_grid(pick_dimension(), pick_dimension(), 15'($urandom),
                      1'($urandom_range(0, 1)));
         cols = grid_cols_q;
         rows = grid_rows_q;
         steady = (phase == 4);
         for (k = 0; k < 150; k++) begin
            item = noise_item();
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
               item.command = CMD_ADD;
               if (cols > 0 && rows > 0 && $urandom_range(0, 99) < 85) begin
                  xl = $urandom_range(0, cols - 1);
                  yl = $urandom_range(0, rows - 1);
                  item = make_add(xl, yl, $urandom_range(xl, cols - 1),
                                  $urandom_range(yl, rows - 1));
               end else if ($urandom_range(0, 1) == 0) begin
                  item.x_high = 16'(cols);
               end
            end else if (roll < 55) begin
               item.command = (roll < 35) ? CMD_SET_FLOOR : CMD_SET_CEILING;
               if (table_count > 0 && $urandom_range(0, 99) < 85)
                  item.region_index = 10'($urandom_range(0, table_count - 1));
            end else begin
               item.command = CMD_LOOKUP;
               roll = $urandom_range(0, 99);
               if (table_count > 0 && roll < 70) begin
                  pick = $urandom_range(0, table_count - 1);
                  item = make_lookup($urandom_range(box_xl[pick], box_xh[pick]),
                                     $urandom_range(box_yl[pick], box_yh[pick]));
               end else if (roll < 85) begin
                  item = make_lookup($urandom_range(0, (cols > 0) ? cols - 1 : 0),
                                     $urandom_range(0, (rows > 0) ? rows - 1 : 0));
               end
            end
            send_item(item);
         end
      end
      steady = 1'b0;
      drain();
   endtask

   task automatic test_full_table();
      int xl, yl;
      program_grid(15'd64, 15'd64, 15'd64, 1'b0);
      while (table_count < MAX_REGIONS) begin
         xl = $urandom_range(0, 63);
         yl = $urandom_range(0, 63);
         send_item(make_add(xl, yl, $urandom_range(xl, 63), $urandom_range(yl, 63)));
      end
      send_item(make_add(0, 0, 63, 63));
      send_item(make_add(9, 0, 8, 63));
      send_item(make_lookup(32, 32));
      send_item(make_set(CMD_SET_FLOOR, MAX_REGIONS - 1, 32'h0002_8000, 16'h00A5, 1'b0));
      send_item(make_set(CMD_SET_CEILING, MAX_REGIONS, 32'h0002_8000, 16'h00A5, 1'b0));
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_bounds_checks();
      test_set_commands();
      test_grid_extremes();
      test_random_traffic();
      test_full_table();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("priority_rect_region_table: match");
      end else begin
         $display("priority_rect_region_table: mismatch");
      end
      $finish;
   end

endmodule
